[src/ftx_pkg.sv]
package ftx_pkg;

  // Default slot count of the table
  localparam int unsigned THREAD_SLOTS_DEF = 16;

  // Request types
  localparam logic [1:0] REQ_FUTEX = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_EXIT  = 2'd2;

  // Futex op codes (after the private bit is dropped)
  localparam logic [7:0] PRIVATE_BIT = 8'd128;
  localparam logic [7:0] OP_WAIT     = 8'd0;
  localparam logic [7:0] OP_WAKE     = 8'd1;
  localparam logic [7:0] OP_WAIT_SET = 8'd9;
  localparam logic [7:0] OP_WAKE_SET = 8'd10;

  localparam logic [31:0] ANY_MASK = 32'hFFFF_FFFF;

  // Result status codes
  localparam logic [1:0] ST_WAITING = 2'd0;
  localparam logic [1:0] ST_AGAIN   = 2'd1;
  localparam logic [1:0] ST_NOSUP   = 2'd2;
  localparam logic [1:0] ST_WOKE    = 2'd3;

  localparam int unsigned MAP_BITS = 16;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  thread_slot;
    logic [7:0]  op_code;
    logic [63:0] wait_addr;
    logic [31:0] arg_value;
    logic [31:0] mem_value;
    logic [31:0] mask_value;
  } ftx_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  woken_count;
    logic [15:0] woken_map;
  } ftx_out_t;

  // Flag updates from the controller to the slot flag block
  typedef struct packed {
    logic start;     // thread start at upd index
    logic stop;      // thread exit at upd index
    logic set_wait;  // waiter recorded at upd index
    logic clr_wait;  // waiter released at clr index
  } ftx_flag_op_t;

endpackage

[src/ftx_ram.sv]
module ftx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ftx_flags.sv]
module ftx_flags import ftx_pkg::*; #(
  parameter int unsigned THREAD_SLOTS = THREAD_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ftx_flag_op_t                    op_i,
  input  logic [$clog2(THREAD_SLOTS)-1:0] upd_idx_i,
  input  logic [$clog2(THREAD_SLOTS)-1:0] clr_idx_i,
  output logic [THREAD_SLOTS-1:0]         present_o,
  output logic [THREAD_SLOTS-1:0]         waiting_o,
  output logic                            other_live_o
);

  localparam int unsigned CW = $clog2(THREAD_SLOTS + 1);

  logic [THREAD_SLOTS-1:0] present_q, present_d;
  logic [THREAD_SLOTS-1:0] term_q, term_d;
  logic [THREAD_SLOTS-1:0] waiting_q, waiting_d;
  logic [CW-1:0]           live_cnt_q, live_cnt_d;
  logic                    old_live;

  // live = present and not terminated; a running count avoids a scan
  assign old_live = present_q[upd_idx_i] & ~term_q[upd_idx_i];

  always_comb begin
    present_d  = present_q;
    term_d     = term_q;
    waiting_d  = waiting_q;
    live_cnt_d = live_cnt_q;
    if (op_i.start) begin
      present_d[upd_idx_i] = 1'b1;
      term_d[upd_idx_i]    = 1'b0;
      waiting_d[upd_idx_i] = 1'b0;
      if (!old_live) begin
        live_cnt_d = live_cnt_q + CW'(1);
      end
    end
    if (op_i.stop) begin
      term_d[upd_idx_i]    = 1'b1;
      waiting_d[upd_idx_i] = 1'b0;
      if (old_live) begin
        live_cnt_d = live_cnt_q - CW'(1);
      end
    end
    if (op_i.set_wait) begin
      waiting_d[upd_idx_i] = 1'b1;
    end
    if (op_i.clr_wait) begin
      waiting_d[clr_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= '0;
      term_q     <= '0;
      waiting_q  <= '0;
      live_cnt_q <= '0;
    end else begin
      present_q  <= present_d;
      term_q     <= term_d;
      waiting_q  <= waiting_d;
      live_cnt_q <= live_cnt_d;
    end
  end

  assign present_o    = present_q;
  assign waiting_o    = waiting_q;
  // another live slot exists when the count exceeds the caller's own share
  assign other_live_o = (live_cnt_q - CW'(old_live)) != '0;

endmodule

[src/futex_wait_wake_table_top.sv]
// Start, exit, wait and unsupported requests: result registered on transfer, then moved to
//   the output register. Wake: scans every slot through the address/mask RAM, one per cycle;
//   the result then moves to the output register.
// Flow: one item at a time; a finished result waits while the output register is full, and a
//   new item is taken while the last result waits in the output register.
// Reset (rst_ni, async low) clears all slot flags, the live count and control state.
module futex_wait_wake_table_top import ftx_pkg::*; #(
  parameter int unsigned THREAD_SLOTS = THREAD_SLOTS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ftx_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ftx_out_t out_data_o
);

  localparam int unsigned SW = $clog2(THREAD_SLOTS);
  localparam int unsigned CW = $clog2(THREAD_SLOTS + 1);
  localparam int unsigned RW = 64 + 32;  // wait address + wait mask

  // Controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]  state_q, state_d;

  // Scan counter: read index in flight; entry cnt-1 is evaluated this cycle
  logic [SW:0] cnt_q, cnt_d;
  logic [SW:0] ev_full;
  logic [SW-1:0] ev_idx;

  // Wake operands and running result (payload, no reset)
  logic [63:0]   wk_addr_q, wk_addr_d;
  logic [31:0]   wk_mask_q, wk_mask_d;
  logic [31:0]   limit_q, limit_d;
  logic [CW-1:0] woken_q, woken_d;
  logic [15:0]   map_q, map_d;
  ftx_out_t      res_q, res_d;

  logic     out_valid_q, out_valid_d;
  ftx_out_t out_data_q, out_data_d;

  // Decode of the incoming item
  logic          accept;
  logic [SW-1:0] slot_idx;
  logic          in_range;
  logic [7:0]    cmd;

  ftx_flag_op_t            flag_op;
  logic [THREAD_SLOTS-1:0] present;
  logic [THREAD_SLOTS-1:0] waiting;
  logic                    other_live;

  logic          ram_we;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;
  logic [63:0]   rd_addr;
  logic [31:0]   rd_mask;
  logic          hit;
  logic          move_out;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_idx   = SW'(in_data_i.thread_slot);
  assign in_range   = 32'(in_data_i.thread_slot) < 32'(THREAD_SLOTS);
  assign cmd        = in_data_i.op_code & ~PRIVATE_BIT;

  assign ev_full = cnt_q - (SW + 1)'(1);
  assign ev_idx  = ev_full[SW-1:0];

  assign rd_addr = ram_rdata[RW-1:32];
  assign rd_mask = ram_rdata[31:0];

  // Release test for the entry whose RAM word arrived this cycle
  assign hit = (state_q == S_SCAN) && (cnt_q != '0)
            && present[ev_idx] && waiting[ev_idx]
            && (rd_addr == wk_addr_q) && ((rd_mask & wk_mask_q) != '0)
            && (32'(woken_q) < limit_q);

  assign move_out = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    wk_addr_d = wk_addr_q;
    wk_mask_d = wk_mask_q;
    limit_d   = limit_q;
    woken_d   = woken_q;
    map_d     = map_q;
    res_d     = res_q;
    flag_op   = '0;
    ram_we    = 1'b0;
    ram_wdata = {in_data_i.wait_addr,
                 (cmd == OP_WAIT_SET) ? in_data_i.mask_value : ANY_MASK};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d   = '{status: ST_WAITING, woken_count: '0, woken_map: '0};
          state_d = S_DONE;
          if (in_data_i.req_type == REQ_START) begin
            flag_op.start = in_range;
          end else if (in_data_i.req_type == REQ_EXIT) begin
            flag_op.stop = in_range;
          end else if (in_data_i.req_type != REQ_FUTEX) begin
            res_d.status = ST_NOSUP;
          end else if (cmd inside {OP_WAIT, OP_WAIT_SET}) begin
            if ((in_data_i.mem_value != in_data_i.arg_value) || !in_range || !other_live) begin
              res_d.status = ST_AGAIN;
            end else begin
              flag_op.set_wait = 1'b1;
              ram_we           = 1'b1;
            end
          end else if (cmd inside {OP_WAKE, OP_WAKE_SET}) begin
            wk_addr_d = in_data_i.wait_addr;
            wk_mask_d = (cmd == OP_WAKE_SET) ? in_data_i.mask_value : ANY_MASK;
            // a count with the sign bit set releases nothing
            limit_d   = in_data_i.arg_value[31] ? '0 : in_data_i.arg_value;
            woken_d   = '0;
            map_d     = '0;
            cnt_d     = '0;
            state_d   = S_SCAN;
          end else begin
            res_d.status = ST_NOSUP;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          flag_op.clr_wait = 1'b1;
          woken_d          = woken_q + CW'(1);
          if (32'(ev_full) < 32'(MAP_BITS)) begin
            map_d = map_q | (16'b1 << ev_idx);
          end
        end
        if (32'(cnt_q) == 32'(THREAD_SLOTS)) begin
          // last entry evaluated this cycle
          res_d.status      = ST_WOKE;
          res_d.woken_count = (32'(woken_d) > 32'd31) ? 5'd31 : 5'(woken_d);
          res_d.woken_map   = map_d;
          state_d           = S_DONE;
        end else begin
          cnt_d = cnt_q + (SW + 1)'(1);
        end
      end
      S_DONE: begin
        if (move_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: holds a finished result while the next item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (move_out) begin
      out_valid_d = 1'b1;
      out_data_d  = res_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_addr_q  <= wk_addr_d;
    wk_mask_q  <= wk_mask_d;
    limit_q    <= limit_d;
    woken_q    <= woken_d;
    map_q      <= map_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Per-slot wait address and mask; written by a recorded wait, read by the wake scan
  ftx_ram #(
    .WIDTH (RW),
    .DEPTH (THREAD_SLOTS)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_idx),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[SW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Present, terminated and waiting flags plus the live slot count
  ftx_flags #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_flags (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (flag_op),
    .upd_idx_i    (slot_idx),
    .clr_idx_i    (ev_idx),
    .present_o    (present),
    .waiting_o    (waiting),
    .other_live_o (other_live)
  );

endmodule

[sim/tb_futex_wait_wake_table_top.sv]
`timescale 1ns / 100ps

module tb_futex_wait_wake_table_top;
  import ftx_pkg::*;

  // Slot count under test and codes the package leaves out
  localparam int unsigned SLOTS       = THREAD_SLOTS_DEF;
  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
  localparam logic [7:0]  OP_BAD      = 8'h7F;
  localparam logic [7:0]  OP_BAD_PRIV = 8'hFF;
  localparam logic [7:0]  OP_BAD_LOW  = 8'h82;

  // Run shape
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned HOLD_AT      = 150;    // transfer count that starts the long stall
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;     // longer than a full wake scan
  localparam int unsigned CYCLE_LIMIT  = 250000;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  ftx_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ftx_out_t out_data_o;

  futex_wait_wake_table_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // One directed row: the request, and a hand-typed result where it is obvious
  typedef struct {
    ftx_in_t  req;
    bit       fixed;
    ftx_out_t res;
  } stim_row_t;

  stim_row_t directed_rows[$];

  // Shadow of the slot table, updated as requests transfer in
  bit          thr_present [SLOTS];
  bit          thr_exited  [SLOTS];
  bit          thr_waiting [SLOTS];
  logic [63:0] thr_addr    [SLOTS];
  logic [31:0] thr_mask    [SLOTS];

  ftx_out_t    pending_results[$];
  ftx_out_t    predicted, got, want;

  // Hand-typed result that travels with the request on the input channel
  bit          cur_fixed = 1'b0;
  ftx_out_t    cur_res   = '0;

  // Small pools of keys so that random waits and wakes actually meet
  logic [63:0] addr_pool [4];
  logic [31:0] mask_pool [4];

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_sent     = 0;
  int unsigned rx_served   = 0;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;

  // Next result of the table for one request; updates the shadow state.
  function automatic ftx_out_t predict_futex_result(ftx_in_t req);
    ftx_out_t    res;
    logic [7:0]  cmd;
    logic [31:0] wmask;
    logic [31:0] limit;
    int unsigned woken;
    bit          other;
    res   = '0;
    cmd   = req.op_code & ~PRIVATE_BIT;
    woken = 0;
    other = 1'b0;
    case (req.req_type)
      REQ_START: begin
        thr_present[req.thread_slot] = 1'b1;
        thr_exited[req.thread_slot]  = 1'b0;
        thr_waiting[req.thread_slot] = 1'b0;
        res.status = ST_WAITING;
      end
      REQ_EXIT: begin
        thr_exited[req.thread_slot]  = 1'b1;
        thr_waiting[req.thread_slot] = 1'b0;
        res.status = ST_WAITING;
      end
      REQ_FUTEX: begin
        if (cmd == OP_WAIT || cmd == OP_WAIT_SET) begin
          for (int unsigned i = 0; i < SLOTS; i++) begin
            if (i != req.thread_slot && thr_present[i] && !thr_exited[i]) other = 1'b1;
          end
          if (req.mem_value != req.arg_value || !other) begin
            res.status = ST_AGAIN;
          end else begin
            thr_waiting[req.thread_slot] = 1'b1;
            thr_addr[req.thread_slot]    = req.wait_addr;
            thr_mask[req.thread_slot]    = (cmd == OP_WAIT_SET) ? req.mask_value : ANY_MASK;
            res.status = ST_WAITING;
          end
        end else if (cmd == OP_WAKE || cmd == OP_WAKE_SET) begin
          wmask = (cmd == OP_WAKE_SET) ? req.mask_value : ANY_MASK;
          // negative count releases nobody
          limit = req.arg_value[31] ? 32'd0 : req.arg_value;
          for (int unsigned i = 0; i < SLOTS; i++) begin
            if (woken >= limit) break;
            if (thr_present[i] && thr_waiting[i] && thr_addr[i] == req.wait_addr &&
                (thr_mask[i] & wmask) != 32'd0) begin
              thr_waiting[i]     = 1'b0;
              woken++;
              res.woken_map[i]   = 1'b1;
            end
          end
          res.status      = ST_WOKE;
          res.woken_count = 5'(woken);
        end else begin
          res.status = ST_NOSUP;
        end
      end
      default: res.status = ST_NOSUP;
    endcase
    return res;
  endfunction

  function automatic ftx_in_t futex_req(logic [1:0] kind, logic [3:0] slot, logic [7:0] op,
                                        logic [63:0] addr, logic [31:0] arg,
                                        logic [31:0] mem, logic [31:0] mask);
    return '{kind, slot, op, addr, arg, mem, mask};
  endfunction

  function automatic stim_row_t fixed_row(ftx_in_t req, logic [1:0] st);
    stim_row_t r;
    r.req        = req;
    r.fixed      = 1'b1;
    r.res        = '0;
    r.res.status = st;
    return r;
  endfunction

  function automatic stim_row_t modeled_row(ftx_in_t req);
    stim_row_t r;
    r.req   = req;
    r.fixed = 1'b0;
    r.res   = '0;
    return r;
  endfunction

  // Mostly well-formed waits and wakes on pooled keys; the rest is noise.
  function automatic ftx_in_t random_request();
    ftx_in_t     r;
    int unsigned pick;
    logic [7:0]  priv;
    pick          = $urandom_range(0, 99);
    priv          = ($urandom_range(0, 1) != 0) ? PRIVATE_BIT : 8'd0;
    r.req_type    = REQ_FUTEX;
    r.thread_slot = 4'($urandom_range(0, 15));
    r.op_code     = OP_WAIT | priv;
    r.wait_addr   = addr_pool[$urandom_range(0, 3)];
    r.arg_value   = $urandom;
    r.mem_value   = r.arg_value;
    r.mask_value  = mask_pool[$urandom_range(0, 3)];
    if (pick < 10) begin
      r.req_type = REQ_START;
    end else if (pick < 15) begin
      r.req_type = REQ_EXIT;
    end else if (pick < 50) begin
      if ($urandom_range(0, 1) != 0) r.op_code = OP_WAIT_SET | priv;
    end else if (pick < 80) begin
      r.op_code = (($urandom_range(0, 1) != 0) ? OP_WAKE_SET : OP_WAKE) | priv;
      case ($urandom_range(0, 5))
        0:       r.arg_value = 32'h7FFF_FFFF;
        1:       r.arg_value = $urandom | 32'h8000_0000;
        default: r.arg_value = $urandom_range(0, 17);
      endcase
      if ($urandom_range(0, 7) == 0) r.mask_value = $urandom;
    end else if (pick < 88) begin
      // value changed under the waiter
      r.mem_value = r.arg_value ^ (32'd1 << $urandom_range(0, 31));
    end else if (pick < 94) begin
      r.op_code = 8'($urandom);
    end else if (pick < 97) begin
      r.req_type = REQ_UNKNOWN;
    end else begin
      r.req_type   = 2'($urandom_range(0, 3));
      r.op_code    = 8'($urandom);
      r.wait_addr  = {$urandom, $urandom};
      r.mem_value  = $urandom;
      r.mask_value = $urandom;
    end
    return r;
  endfunction

  // Sender: random gap (none in calm stretches), then hold valid until transfer
  task automatic offer_request(ftx_in_t req, bit fixed, ftx_out_t res);
    int unsigned gap;
    if (tx_sent % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    cur_fixed  <= fixed;
    cur_res    <= res;
    do @(posedge clk_i); while (!in_ready_o);
    tx_sent++;
  endtask

  // Receiver: random stall per result, one long hold-off to back up the block
  initial begin : result_sink
    int unsigned stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (rx_served % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (rx_served == HOLD_AT) stall = HOLD_CYCLES;
      else stall = rx_calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      rx_served++;
    end
  end

  // Monitor: check the output transfer first, then queue the new expectation,
  // so a result never meets the request that enters on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, got);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            err_count++;
          end
          if (got.woken_count !== want.woken_count) begin
            $display("%0t: woken_count mismatch, expected %0d, got %0d",
                     $time, want.woken_count, got.woken_count);
            err_count++;
          end
          if (got.woken_map !== want.woken_map) begin
            $display("%0t: woken_map mismatch, expected %h, got %h",
                     $time, want.woken_map, got.woken_map);
            err_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        // predictor always runs to keep the shadow table in step
        predicted = predict_futex_result(in_data_i);
        pending_results.push_back(cur_fixed ? cur_res : predicted);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < 4; k++) begin
      addr_pool[k] = {$urandom, $urandom};
      mask_pool[k] = ($urandom_range(0, 1) != 0) ? (32'd1 << $urandom_range(0, 31)) : $urandom;
    end

    // Directed part: empty table, unknown codes, count extremes, lone caller,
    // caller not present, exit releasing a waiter, wake limit.
    directed_rows.push_back(fixed_row(futex_req(REQ_FUTEX, 4'd0, OP_WAIT, 64'd0,
                                                32'd0, 32'd0, 32'd0), ST_AGAIN));
    directed_rows.push_back(fixed_row(futex_req(REQ_UNKNOWN, 4'd15, OP_BAD_PRIV, '1,
                                                '1, '1, '1), ST_NOSUP));
    directed_rows.push_back(fixed_row(futex_req(REQ_FUTEX, 4'd0, OP_BAD, 64'd0,
                                                32'd0, 32'd0, 32'd0), ST_NOSUP));
    directed_rows.push_back(fixed_row(futex_req(REQ_START, 4'd0, OP_WAIT, 64'd0,
                                                32'd0, 32'd0, 32'd0), ST_WAITING));
    directed_rows.push_back(fixed_row(futex_req(REQ_START, 4'd15, OP_WAIT, 64'd0,
                                                32'd0, 32'd0, 32'd0), ST_WAITING));
    directed_rows.push_back(modeled_row(futex_req(REQ_FUTEX, 4'd0, OP_WAIT, '1,
                                                  '1, '1, 32'd0)));
    directed_rows.push_back(fixed_row(futex_req(REQ_FUTEX, 4'd15, OP_WAIT_SET, '1,
                                                32'd0, 32'd1, 32'd0), ST_AGAIN));
    directed_rows.push_back(modeled_row(futex_req(REQ_FUTEX, 4'd15, OP_WAIT_SET | PRIVATE_BIT,
                                                  '1, 32'd0, 32'd0, 32'h8000_0000)));
    directed_rows.push_back(fixed_row(futex_req(REQ_FUTEX, 4'd3, OP_WAKE, '1,
                                                32'h8000_0000, 32'd0, 32'd0), ST_WOKE));
    directed_rows.push_back(fixed_row(futex_req(REQ_FUTEX, 4'd3, OP_WAKE, '1,
                                                32'd0, 32'd0, 32'd0), ST_WOKE));
    directed_rows.push_back(modeled_row(futex_req(REQ_FUTEX, 4'd3, OP_WAKE_SET, '1,
                                                  32'd16, 32'd0, 32'd1)));
    directed_rows.push_back(modeled_row(futex_req(REQ_FUTEX, 4'd3, OP_WAKE | PRIVATE_BIT, '1,
                                                  32'h7FFF_FFFF, 32'd0, 32'd0)));
    directed_rows.push_back(fixed_row(futex_req(REQ_EXIT, 4'd15, OP_WAIT, 64'd0,
                                                32'd0, 32'd0, 32'd0), ST_WAITING));
    directed_rows.push_back(modeled_row(futex_req(REQ_FUTEX, 4'd0, OP_WAIT, 64'd0,
                                                  32'd0, 32'd0, 32'd0)));
    directed_rows.push_back(modeled_row(futex_req(REQ_FUTEX, 4'd3, OP_WAIT, 64'd0,
                                                  32'd5, 32'd5, 32'd0)));
    directed_rows.push_back(modeled_row(futex_req(REQ_START, 4'd7, OP_WAIT, 64'd0,
                                                  32'd0, 32'd0, 32'd0)));
    directed_rows.push_back(modeled_row(futex_req(REQ_FUTEX, 4'd7, OP_WAIT_SET, 64'd0,
                                                  32'd7, 32'd7, 32'd1)));
    directed_rows.push_back(modeled_row(futex_req(REQ_FUTEX, 4'd0, OP_WAIT, 64'd0,
                                                  32'd0, 32'd0, 32'd0)));
    directed_rows.push_back(modeled_row(futex_req(REQ_FUTEX, 4'd5, OP_WAKE, 64'd0,
                                                  32'd1, 32'd0, 32'd0)));
    directed_rows.push_back(modeled_row(futex_req(REQ_EXIT, 4'd7, OP_WAIT, 64'd0,
                                                  32'd0, 32'd0, 32'd0)));
    directed_rows.push_back(modeled_row(futex_req(REQ_FUTEX, 4'd5, OP_WAKE_SET, 64'd0,
                                                  32'd2, 32'd0, ANY_MASK)));
    directed_rows.push_back(fixed_row(futex_req(REQ_FUTEX, 4'd2, OP_BAD_PRIV, 64'd0,
                                                32'd0, 32'd0, 32'd0), ST_NOSUP));
    directed_rows.push_back(fixed_row(futex_req(REQ_FUTEX, 4'd2, OP_BAD_LOW, 64'd0,
                                                32'd0, 32'd0, 32'd0), ST_NOSUP));
    directed_rows.push_back(modeled_row(futex_req(REQ_START, 4'd7, OP_WAIT, 64'd0,
                                                  32'd0, 32'd0, 32'd0)));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[n]) begin
      offer_request(directed_rows[n].req, directed_rows[n].fixed, directed_rows[n].res);
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // rotate keys now and then so fresh address and mask bits show up
      if (n % 50 == 49) begin
        addr_pool[$urandom_range(0, 3)] = {$urandom, $urandom};
        mask_pool[$urandom_range(0, 3)] = ($urandom_range(0, 1) != 0) ?
                                          (32'd1 << $urandom_range(0, 31)) : $urandom;
      end
      offer_request(random_request(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
